// ===== hdl/preemptive_priority_tick_scheduler_assert.svh =====
// assertion macros used by the scheduler rtl
// no dependencies; include by bare file name
`ifndef PREEMPTIVE_PRIORITY_TICK_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_TICK_SCHEDULER_ASSERT_SVH

// same-cycle implication under async active-low reset
`define PPTS_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error("ppts check failed");

// next-cycle implication under async active-low reset
`define PPTS_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error("ppts check failed");

`endif

// ===== hdl/ppts_pkg.sv =====
// shared constants, opcodes and types for the priority tick scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppts_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int TIME_W  = 32;

	localparam logic [7:0] AGE_LIMIT_RESET = 8'd5;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [15:0] remaining;
		logic [15:0] burst;
		logic [15:0] arrival;
		logic [7:0]  prio;
		logic [7:0]  age;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             wr_busy;
		logic             clr_all;
	} tbl_req_t;

	typedef struct packed {
		logic              ran;
		logic [7:0]        served_index;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] now;
		logic              all_done;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/ppts_table.sv =====
// task table: one synchronous memory of entries plus per-slot busy flags
// depends on ppts_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppts_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ppts_pkg::tbl_req_t req,
	output ppts_pkg::entry_t       rd_data,
	output logic                   rd_busy,
	output logic                   wr_busy_old
);

	ppts_pkg::entry_t mem [ppts_pkg::ENTRIES];
	logic [ppts_pkg::ENTRIES-1:0] busy_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

	// busy flag marks slots with remaining time, cleared at once by a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			rd_busy <= 1'b0;
		end else begin
			if (req.clr_all) begin
				busy_q <= '0;
			end else if (req.wr_en) begin
				busy_q[req.wr_addr] <= req.wr_busy;
			end
			if (req.rd_en) begin
				rd_busy <= busy_q[req.rd_addr];
			end
		end
	end

	assign wr_busy_old = busy_q[req.wr_addr];

endmodule

`default_nettype wire

// ===== hdl/ppts_sched.sv =====
// request sequencer: load/clear handling, table scan, update and write-back
// depends on ppts_pkg, ppts_table and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_tick_scheduler_assert.svh"

module ppts_sched (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    opcode,
	input  wire logic [7:0]    entry_index,
	input  wire logic [15:0]   burst,
	input  wire logic [15:0]   arrival,
	input  wire logic [7:0]    start_priority,
	input  wire logic [7:0]    age_limit,
	output logic               res_valid,
	input  wire logic          res_ready,
	output ppts_pkg::res_t     res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;

	localparam int IW = ppts_pkg::IDX_W;
	localparam logic [IW:0]   SCAN_END  = (IW + 1)'(ppts_pkg::ENTRIES);
	localparam logic [IW-1:0] LAST_ADDR = IW'(ppts_pkg::ENTRIES - 1);

	logic [2:0] state_q;
	logic [IW:0] issue_q;
	logic vld_s1;
	logic [IW-1:0] addr_s1;
	logic found_q;
	logic [IW-1:0] pick_q;
	ppts_pkg::entry_t best_q;
	logic [ppts_pkg::TIME_W-1:0] cur_time_q;
	logic [ppts_pkg::CNT_W-1:0] pend_q;
	logic ran_q;
	logic fin_q;
	logic [7:0] served_q;
	logic [ppts_pkg::TIME_W-1:0] turn_q;

	ppts_pkg::tbl_req_t req;
	ppts_pkg::entry_t rd_data;
	logic rd_busy;
	logic wr_busy_old;

	logic acc;
	logic in_range;
	logic cand;
	logic [15:0] rem_dec;
	logic upd_fin;
	logic age_hit;
	ppts_pkg::entry_t upd_entry;
	logic [ppts_pkg::TIME_W-1:0] time_inc;

	ppts_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rd_data     (rd_data),
		.rd_busy     (rd_busy),
		.wr_busy_old (wr_busy_old)
	);

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign in_range = (32'(entry_index) < ppts_pkg::ENTRIES);

	// candidate test on the entry read last cycle
	assign cand = vld_s1 && rd_busy
		&& (ppts_pkg::TIME_W'(rd_data.arrival) <= cur_time_q)
		&& (!found_q || (rd_data.prio > best_q.prio));

	// service of the chosen entry
	assign rem_dec  = best_q.remaining - 16'd1;
	assign upd_fin  = (rem_dec == 16'd0);
	assign age_hit  = (best_q.age >= age_limit);
	assign time_inc = (cur_time_q == '1) ? cur_time_q : cur_time_q + 1'b1;

	always_comb begin
		upd_entry           = best_q;
		upd_entry.remaining = rem_dec;
		if (age_hit) begin
			upd_entry.age = 8'd0;
			if (best_q.prio != 8'd0) begin
				upd_entry.prio = best_q.prio - 8'd1;
			end
		end else begin
			upd_entry.age = best_q.age + 8'd1;
		end
	end

	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (acc && (opcode == ppts_pkg::OP_LOAD) && in_range) begin
					req.wr_en             = 1'b1;
					req.wr_addr           = IW'(entry_index);
					req.wr_data.remaining = burst;
					req.wr_data.burst     = burst;
					req.wr_data.arrival   = arrival;
					req.wr_data.prio      = start_priority;
					req.wr_data.age       = 8'd0;
					req.wr_busy           = (burst != 16'd0);
				end
				if (acc && (opcode == ppts_pkg::OP_CLEAR)) begin
					req.clr_all = 1'b1;
				end
			end
			S_SCAN: begin
				req.rd_en   = (issue_q < SCAN_END);
				req.rd_addr = issue_q[IW-1:0];
			end
			S_UPD: begin
				if (found_q) begin
					req.wr_en   = 1'b1;
					req.wr_addr = pick_q;
					req.wr_data = upd_entry;
					req.wr_busy = !upd_fin;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issue_q    <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			cur_time_q <= '0;
			pend_q     <= '0;
		end else begin
			vld_s1 <= (state_q == S_SCAN) && req.rd_en;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (opcode)
							ppts_pkg::OP_LOAD: begin
								if (in_range) begin
									if (!wr_busy_old && req.wr_busy) begin
										pend_q <= pend_q + 1'b1;
									end else if (wr_busy_old && !req.wr_busy) begin
										pend_q <= pend_q - 1'b1;
									end
								end
								state_q <= S_FIN;
							end
							ppts_pkg::OP_TICK: begin
								issue_q <= '0;
								found_q <= 1'b0;
								state_q <= S_SCAN;
							end
							ppts_pkg::OP_CLEAR: begin
								cur_time_q <= '0;
								pend_q     <= '0;
								state_q    <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (req.rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (cand) begin
						found_q <= 1'b1;
					end
					if (vld_s1 && (addr_s1 == LAST_ADDR)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					cur_time_q <= time_inc;
					if (found_q && upd_fin) begin
						pend_q <= pend_q - 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= req.rd_addr;
		case (state_q)
			S_IDLE: begin
				ran_q    <= 1'b0;
				fin_q    <= 1'b0;
				served_q <= 8'd0;
			end
			S_SCAN: begin
				if (cand) begin
					best_q <= rd_data;
					pick_q <= addr_s1;
				end
			end
			S_UPD: begin
				if (found_q) begin
					ran_q    <= 1'b1;
					served_q <= 8'(pick_q);
					fin_q    <= upd_fin;
				end
				turn_q <= time_inc - ppts_pkg::TIME_W'(best_q.arrival);
			end
			default: begin
			end
		endcase
	end

	assign res_valid        = (state_q == S_FIN);
	assign res.ran          = ran_q;
	assign res.served_index = served_q;
	assign res.finished     = fin_q;
	assign res.turnaround   = fin_q ? turn_q : '0;
	assign res.waiting      = (fin_q && (turn_q >= ppts_pkg::TIME_W'(best_q.burst)))
		? turn_q - ppts_pkg::TIME_W'(best_q.burst) : '0;
	assign res.now          = cur_time_q;
	assign res.all_done     = (pend_q == '0);

	`PPTS_ASSERT_NOW(a_pend_range, clk, arst_n, 1'b1, pend_q <= ppts_pkg::CNT_W'(ppts_pkg::ENTRIES))
	`PPTS_ASSERT_NEXT(a_time_mono, clk, arst_n, !(acc && (opcode == ppts_pkg::OP_CLEAR)), cur_time_q >= $past(cur_time_q))
	`PPTS_ASSERT_NOW(a_fin_ran, clk, arst_n, res_valid && res.finished, res.ran)
	`PPTS_ASSERT_NOW(a_scan_no_write, clk, arst_n, state_q == S_SCAN, !req.wr_en && !req.clr_all)

endmodule

`default_nettype wire

// ===== hdl/preemptive_priority_tick_scheduler.sv =====
// Preemptive priority tick scheduler with aging. A 256-slot task table sits in
// one synchronous memory (entry fields) plus a busy flag per slot held in
// flip-flops, so reset and the clear request empty the table at once with no
// clearing pass. A load or clear request finishes without a table scan. A
// tick request scans every slot, one memory read per cycle, then writes back
// the served slot, if one was found; the scan rate is bound by the
// single read port of the table memory. Requests are handled one at a time;
// the result sits in an output register so the next request is accepted while
// a result waits downstream. age_limit is written through cfg_wr_en/cfg_wr_data
// and must only change while the block is idle.
// depends on ppts_pkg and ppts_sched
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_tick_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  entry_index,
	input  wire logic [15:0] burst,
	input  wire logic [15:0] arrival,
	input  wire logic [7:0]  start_priority,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ran,
	output logic [7:0]       served_index,
	output logic             finished,
	output logic [31:0]      turnaround,
	output logic [31:0]      waiting,
	output logic [31:0]      now,
	output logic             all_done,
	// age limit register
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data
);

	logic [7:0] age_limit_q;
	logic res_valid;
	logic res_ready;
	ppts_pkg::res_t res;
	ppts_pkg::res_t out_q;
	logic out_valid_q;

	// age limit, reset to five run ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= ppts_pkg::AGE_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			age_limit_q <= cfg_wr_data;
		end
	end

	ppts_sched u_sched (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.entry_index    (entry_index),
		.burst          (burst),
		.arrival        (arrival),
		.start_priority (start_priority),
		.age_limit      (age_limit_q),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

	// output register: takes a new result when empty or being drained
	assign res_ready = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign ran          = out_q.ran;
	assign served_index = out_q.served_index;
	assign finished     = out_q.finished;
	assign turnaround   = out_q.turnaround;
	assign waiting      = out_q.waiting;
	assign now          = out_q.now;
	assign all_done     = out_q.all_done;

endmodule

`default_nettype wire
